// ===== hdl/ltc_pkg.sv =====
package ltc_pkg;

    localparam int MAX_TOKEN_LEN = 255;
    localparam int RUN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    typedef enum logic [2:0] {
        KIND_KEYWORD  = 3'd0,
        KIND_NUMBER   = 3'd1,
        KIND_IDENT    = 3'd2,
        KIND_STRING   = 3'd3,
        KIND_OPERATOR = 3'd4,
        KIND_SYMBOL   = 3'd5
    } token_kind_t;

    typedef struct packed {
        logic        valid;
        token_kind_t kind;
        logic [7:0]  length;
        logic [7:0]  ch;
    } token_t;

    // tok0 is the flushed word, tok1 the token raised by the character itself
    typedef struct packed {
        token_t tok0;
        token_t tok1;
    } token_cmd_t;

    function automatic logic [7:0] kw_int_char(input logic [RUN_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (pos)
            RUN_W'(0): c = 8'h69;
            RUN_W'(1): c = 8'h6E;
            RUN_W'(2): c = 8'h74;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_return_char(input logic [RUN_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (pos)
            RUN_W'(0): c = 8'h72;
            RUN_W'(1): c = 8'h65;
            RUN_W'(2): c = 8'h74;
            RUN_W'(3): c = 8'h75;
            RUN_W'(4): c = 8'h72;
            RUN_W'(5): c = 8'h6E;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sat_len(input logic [RUN_W-1:0] run);
        logic [7:0] r;
        if (17'(run) > 17'd255)
        begin
            r = 8'hFF;
        end
        else
        begin
            r = 8'(run);
        end
        return r;
    endfunction

endpackage

// ===== hdl/lexical_token_classifier.sv =====
// Lexical token classifier: one character transaction per cycle in while
// s_tready is high, tokens out. Input tdata carries the character byte and
// an end-of-line flag; each accepted character updates the open word or
// string and queues the tokens it closes (at most two) in a 4-entry command
// queue. The output side drains it through a registered output stage at one
// token per cycle while m_tready is high, with tlast on the final token raised
// by a character. A character that closes a word and raises an operator or
// symbol yields two output tokens, so sustained input rate is one character
// per cycle unless such pairs keep the queue full. Lengths saturate at 255.
module lexical_token_classifier
    import ltc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_code, [8] line_end, [15:9] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] token_kind, [10:3] token_length,
                                   // [18:11] single_char, [23:19] zero
    output logic        m_tlast
);

    token_cmd_t  cmd;
    token_cmd_t  head;
    logic        cmd_valid;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    token_kind_t token_kind;
    logic [7:0]  token_length;
    logic [7:0]  single_char;

    ltc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_code (s_tdata[7:0]),
        .line_end  (s_tdata[8]),
        .q_full    (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    ltc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .pop      (q_pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    ltc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .token_kind   (token_kind),
        .token_length (token_length),
        .single_char  (single_char),
        .last_result  (m_tlast)
    );

    assign m_tdata = {5'd0, single_char, token_length, token_kind};

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_valid && q_full))
        else $error("token queue overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("pop from empty token queue");

    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (token_kind == KIND_OPERATOR || token_kind == KIND_SYMBOL))
        |-> (token_length == 8'd1))
        else $error("operator or symbol with length other than one");

    a_keyword_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && token_kind == KIND_KEYWORD)
        |-> (token_length == 8'd3 || token_length == 8'd6))
        else $error("keyword with bad length");

endmodule

// ===== hdl/ltc_front.sv =====
module ltc_front
    import ltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       line_end,
    input  logic       q_full,
    output logic       cmd_valid,
    output token_cmd_t cmd
);

    logic             in_string_reg, in_string_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             digit_first_reg, digit_first_next;
    logic             int_match_reg, int_match_next;
    logic             ret_match_reg, ret_match_next;

    logic             acc;
    logic             is_digit;
    logic             is_word;
    logic [RUN_W-1:0] grown;
    token_kind_t      word_kind;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;
    assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
    assign is_word  = is_digit || ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                      ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                      (char_code == CH_UNDERSCORE);
    assign grown    = (run_reg < RUN_W'(MAX_TOKEN_LEN)) ? run_reg + RUN_W'(1) : run_reg;

    always_comb
    begin
        if ((int_match_reg && run_reg == RUN_W'(3)) ||
            (ret_match_reg && run_reg == RUN_W'(6)))
        begin
            word_kind = KIND_KEYWORD;
        end
        else if (digit_first_reg)
        begin
            word_kind = KIND_NUMBER;
        end
        else
        begin
            word_kind = KIND_IDENT;
        end
    end

    always_comb
    begin
        in_string_next   = in_string_reg;
        run_next         = run_reg;
        digit_first_next = digit_first_reg;
        int_match_next   = int_match_reg;
        ret_match_next   = ret_match_reg;
        cmd              = '0;
        cmd.tok0.kind    = word_kind;
        cmd.tok0.length  = sat_len(run_reg);
        cmd.tok1.kind    = KIND_SYMBOL;
        cmd.tok1.length  = 8'd1;

        if (line_end)
        begin
            if (in_string_reg)
            begin
                cmd.tok1.valid  = 1'b1;
                cmd.tok1.kind   = KIND_STRING;
                cmd.tok1.length = sat_len(grown);
            end
            else
            begin
                cmd.tok0.valid = (run_reg != '0);
            end
            in_string_next   = 1'b0;
            run_next         = '0;
            digit_first_next = 1'b0;
            int_match_next   = 1'b1;
            ret_match_next   = 1'b1;
        end
        else if (in_string_reg)
        begin
            run_next = grown;
            if (char_code == CH_QUOTE)
            begin
                cmd.tok1.valid   = 1'b1;
                cmd.tok1.kind    = KIND_STRING;
                cmd.tok1.length  = sat_len(grown);
                in_string_next   = 1'b0;
                run_next         = '0;
                digit_first_next = 1'b0;
                int_match_next   = 1'b1;
                ret_match_next   = 1'b1;
            end
        end
        else if (is_word)
        begin
            if (run_reg == '0)
            begin
                digit_first_next = is_digit;
            end
            int_match_next = int_match_reg && (run_reg < RUN_W'(3)) &&
                             (char_code == kw_int_char(run_reg));
            ret_match_next = ret_match_reg && (run_reg < RUN_W'(6)) &&
                             (char_code == kw_return_char(run_reg));
            run_next       = grown;
        end
        else
        begin
            cmd.tok0.valid   = (run_reg != '0);
            run_next         = '0;
            digit_first_next = 1'b0;
            int_match_next   = 1'b1;
            ret_match_next   = 1'b1;
            if (char_code == CH_QUOTE)
            begin
                in_string_next = 1'b1;
                run_next       = RUN_W'(1);
            end
            else if (char_code != CH_SPACE)
            begin
                cmd.tok1.valid = 1'b1;
                cmd.tok1.ch    = char_code;
                if (char_code == CH_EQUAL || char_code == CH_LESS ||
                    char_code == CH_GREATER)
                begin
                    cmd.tok1.kind = KIND_OPERATOR;
                end
            end
        end
    end

    assign cmd_valid = acc && (cmd.tok0.valid || cmd.tok1.valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_string_reg   <= 1'b0;
            run_reg         <= '0;
            digit_first_reg <= 1'b0;
            int_match_reg   <= 1'b1;
            ret_match_reg   <= 1'b1;
        end
        else if (acc)
        begin
            in_string_reg   <= in_string_next;
            run_reg         <= run_next;
            digit_first_reg <= digit_first_next;
            int_match_reg   <= int_match_next;
            ret_match_reg   <= ret_match_next;
        end
    end

endmodule

// ===== hdl/ltc_queue.sv =====
module ltc_queue
    import ltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  token_cmd_t push_cmd,
    input  logic       pop,
    output token_cmd_t head,
    output logic       full,
    output logic       empty
);

    token_cmd_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/ltc_back.sv =====
module ltc_back
    import ltc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  token_cmd_t  head,
    input  logic        q_empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output token_kind_t token_kind,
    output logic [7:0]  token_length,
    output logic [7:0]  single_char,
    output logic        last_result
);

    logic        phase_reg, phase_next;
    logic        out_valid_reg;
    token_kind_t kind_reg;
    logic [7:0]  len_reg;
    logic [7:0]  ch_reg;
    logic        last_reg;
    logic        load;
    token_t      sel;
    logic        sel_last;

    assign load = !q_empty && (!out_valid_reg || out_ready);

    // emit the word token first, then the one raised by the character
    always_comb
    begin
        if (!phase_reg && head.tok0.valid)
        begin
            sel        = head.tok0;
            sel_last   = !head.tok1.valid;
            pop        = load && !head.tok1.valid;
            phase_next = head.tok1.valid;
        end
        else
        begin
            sel        = head.tok1;
            sel_last   = 1'b1;
            pop        = load;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                phase_reg <= phase_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= sel.kind;
            len_reg  <= sel.length;
            ch_reg   <= sel.ch;
            last_reg <= sel_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign token_length = len_reg;
    assign single_char  = ch_reg;
    assign last_result  = last_reg;

endmodule

// ===== tb/tb_lexical_token_classifier.sv =====
`timescale 1ns / 1ps

module tb_lexical_token_classifier;
    import ltc_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          HOLD_AT       = 250;
    localparam int          HOLD_LEN      = 300;
    localparam int          QUIET_FROM    = 500;
    localparam int          QUIET_TO      = 750;
    localparam logic [23:0] KW_INT        = "int";
    localparam logic [47:0] KW_RETURN     = "return";

    typedef struct packed {
        logic       eol;
        logic [7:0] ch;
    } char_item_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  length;
        logic [7:0]  ch;
        logic        last;
    } token_exp_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    char_item_t  pending[$];
    char_item_t  next_item;
    token_exp_t  staged[$];
    token_exp_t  token_fifo[$];
    token_exp_t  want;

    // tokenizer state
    bit          in_str;
    int unsigned run_len;
    bit          lead_digit;
    bit          int_match;
    bit          ret_match;

    int          cycle_count    = 0;
    int          accepted_count = 0;
    int          checked_count  = 0;
    int          mismatch_count = 0;
    int          kind_tally[6];
    int          hold_cycles;
    bit          hold_done;

    lexical_token_classifier i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic void restart_run();
        run_len    = 0;
        lead_digit = 1'b0;
        int_match  = 1'b1;
        ret_match  = 1'b1;
    endfunction

    function automatic void lengthen();
        if (run_len < MAX_TOKEN_LEN)
        begin
            run_len++;
        end
    endfunction

    function automatic void emit(token_kind_t kind, int unsigned len, logic [7:0] ch);
        token_exp_t t;
        t.kind   = kind;
        t.length = (len > 255) ? 8'hFF : 8'(len);
        t.ch     = ch;
        t.last   = 1'b0;
        staged.push_back(t);
    endfunction

    function automatic void close_word();
        if (run_len == 0)
        begin
            return;
        end
        if ((int_match && run_len == 3) || (ret_match && run_len == 6))
        begin
            emit(KIND_KEYWORD, run_len, 8'h00);
        end
        else if (lead_digit)
        begin
            emit(KIND_NUMBER, run_len, 8'h00);
        end
        else
        begin
            emit(KIND_IDENT, run_len, 8'h00);
        end
        restart_run();
    endfunction

    function automatic void tokenize_char(logic [7:0] ch, logic eol);
        bit is_digit;
        bit is_word;
        is_digit = (ch >= "0") && (ch <= "9");
        is_word  = is_digit || ((ch >= "a") && (ch <= "z")) ||
                   ((ch >= "A") && (ch <= "Z")) || (ch == CH_UNDERSCORE);
        staged.delete();
        if (eol)
        begin
            if (in_str)
            begin
                lengthen();
                emit(KIND_STRING, run_len, 8'h00);
                in_str = 1'b0;
                restart_run();
            end
            else
            begin
                close_word();
            end
        end
        else if (in_str)
        begin
            lengthen();
            if (ch == CH_QUOTE)
            begin
                emit(KIND_STRING, run_len, 8'h00);
                in_str = 1'b0;
                restart_run();
            end
        end
        else if (is_word)
        begin
            if (run_len == 0)
            begin
                lead_digit = is_digit;
            end
            if (run_len < 3)
            begin
                int_match = int_match && (ch == KW_INT[8*(2-run_len) +: 8]);
            end
            else
            begin
                int_match = 1'b0;
            end
            if (run_len < 6)
            begin
                ret_match = ret_match && (ch == KW_RETURN[8*(5-run_len) +: 8]);
            end
            else
            begin
                ret_match = 1'b0;
            end
            lengthen();
        end
        else
        begin
            close_word();
            if (ch == CH_SPACE)
            begin
                // dropped
            end
            else if (ch == CH_QUOTE)
            begin
                in_str = 1'b1;
                restart_run();
                lengthen();
            end
            else if (ch == CH_EQUAL || ch == CH_LESS || ch == CH_GREATER)
            begin
                emit(KIND_OPERATOR, 1, ch);
            end
            else
            begin
                emit(KIND_SYMBOL, 1, ch);
            end
        end
        if (staged.size() > 0)
        begin
            staged[staged.size()-1].last = 1'b1;
        end
        foreach (staged[i])
        begin
            token_fifo.push_back(staged[i]);
        end
    endfunction

    function automatic bit idle_now();
        bit quiet;
        quiet = (accepted_count >= QUIET_FROM) && (accepted_count < QUIET_TO);
        return !quiet && ($urandom_range(99) < 8);
    endfunction

    function automatic void queue_char(logic [7:0] ch, logic eol);
        char_item_t it;
        it.ch  = ch;
        it.eol = eol;
        pending.push_back(it);
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            queue_char(s[i], 1'b0);
        end
    endfunction

    function automatic logic [7:0] word_char();
        int k;
        k = $urandom_range(62);
        if (k < 10)
        begin
            return 8'("0" + k);
        end
        else if (k < 36)
        begin
            return 8'("a" + k - 10);
        end
        else if (k < 62)
        begin
            return 8'("A" + k - 36);
        end
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] string_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c == CH_QUOTE)
        begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                tokenize_char(s_tdata[7:0], s_tdata[8]);
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending.size() > 0 && !idle_now())
                begin
                    next_item = pending.pop_front();
                    s_tdata  <= {7'd0, next_item.eol, next_item.ch};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end
        else if (!hold_done && accepted_count >= HOLD_AT)
        begin
            hold_cycles <= HOLD_LEN;
            hold_done   <= 1'b1;
            m_tready    <= 1'b0;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
        begin
            m_tready <= !idle_now();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (token_fifo.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected token kind=%0d len=%0d ch=%02h last=%0b",
                         $time, m_tdata[2:0], m_tdata[10:3], m_tdata[18:11], m_tlast);
            end
            else
            begin
                want = token_fifo.pop_front();
                checked_count++;
                if (m_tdata[2:0] !== want.kind || m_tdata[10:3] !== want.length ||
                    m_tdata[18:11] !== want.ch || m_tlast !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: token mismatch, expected kind=%0d len=%0d ch=%02h last=%0b,",
                             $time, want.kind, want.length, want.ch, want.last,
                             " got kind=%0d len=%0d ch=%02h last=%0b",
                             m_tdata[2:0], m_tdata[10:3], m_tdata[18:11], m_tlast);
                end
                else
                begin
                    kind_tally[want.kind]++;
                end
            end
        end
    end

    initial
    begin
        int r;
        int n;
        int long_runs;
        long_runs = 0;
        in_str = 1'b0;
        restart_run();

        // directed: keywords, number, identifier, two operators, strings, eol cases
        queue_text("int return=9z<_\"");
        queue_char(8'hFF, 1'b0);
        queue_char(CH_QUOTE, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_text("A");
        queue_char(8'hFF, 1'b1);
        queue_char(8'h00, 1'b1);
        queue_char(CH_QUOTE, 1'b0);
        queue_char(8'h5A, 1'b1);

        while (pending.size() < 25 + RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                if ($urandom_range(1) != 0)
                begin
                    queue_text("int");
                end
                else
                begin
                    queue_text("return");
                end
            end
            else if (r < 20)
            begin
                case ($urandom_range(3))
                    0:       queue_text("in");
                    1:       queue_text("intx");
                    2:       queue_text("retur");
                    default: queue_text("return_");
                endcase
            end
            else if (r < 38)
            begin
                n = $urandom_range(1, 8);
                repeat (n) queue_char(word_char(), 1'b0);
            end
            else if (r < 50)
            begin
                queue_char(CH_QUOTE, 1'b0);
                n = $urandom_range(0, 10);
                repeat (n) queue_char(string_char(), 1'b0);
                if ($urandom_range(4) == 0)
                begin
                    queue_char(8'($urandom_range(255)), 1'b1);
                end
                else
                begin
                    queue_char(CH_QUOTE, 1'b0);
                end
            end
            else if (r < 62)
            begin
                case ($urandom_range(2))
                    0:       queue_char(CH_EQUAL, 1'b0);
                    1:       queue_char(CH_LESS, 1'b0);
                    default: queue_char(CH_GREATER, 1'b0);
                endcase
            end
            else if (r < 72)
            begin
                queue_char(CH_SPACE, 1'b0);
            end
            else if (r < 80)
            begin
                queue_char(8'($urandom_range(255)), 1'b1);
            end
            else if (r < 98 || long_runs >= 2)
            begin
                queue_char(8'($urandom_range(255)), 1'b0);
            end
            else
            begin
                // saturating runs: one word, one string
                n = $urandom_range(256, 270);
                if (long_runs == 0)
                begin
                    repeat (n) queue_char(word_char(), 1'b0);
                end
                else
                begin
                    queue_char(CH_QUOTE, 1'b0);
                    repeat (n) queue_char(string_char(), 1'b0);
                end
                queue_char(8'($urandom_range(255)), 1'b1);
                long_runs++;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || s_tvalid || token_fifo.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Covered %0d characters and %0d tokens with a %0d-cycle output hold-off",
                 accepted_count, checked_count, HOLD_LEN);
        $display("  kinds: %0d keyword, %0d number, %0d identifier,",
                 kind_tally[0], kind_tally[1], kind_tally[2],
                 " %0d string, %0d operator, %0d symbol",
                 kind_tally[3], kind_tally[4], kind_tally[5]);
        if (mismatch_count == 0)
        begin
            $display("tb_lexical_token_classifier: done, clean");
        end
        else
        begin
            $display("tb_lexical_token_classifier: done, errors");
        end
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d tokens still expected", $time, token_fifo.size());
        $display("tb_lexical_token_classifier: done, errors");
        $finish;
    end

endmodule
